// ----- sv/assert_macros.svh -----
// Assertion helpers, clocked on clk and held off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/phe_pkg.sv -----
package phe_pkg;

  localparam int unsigned MAX_DEGREE_DEF = 63;
  localparam int unsigned DEG_W          = 6;
  localparam int unsigned Q_FRAC         = 16;
  localparam int unsigned SUM_W          = 50;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EVAL  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_OVF   = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [DEG_W-1:0]   coeff_index;
    logic signed [31:0] coeff_value;
    logic signed [31:0] point_re;
    logic signed [31:0] point_im;
  } phe_req_t;

  typedef struct packed {
    logic signed [31:0] value_re;
    logic signed [31:0] value_im;
    logic [1:0]         status;
  } phe_rsp_t;

  // Q16.16 product scaled back, rounded toward zero
  function automatic logic signed [SUM_W-1:0] q_trunc(input logic signed [63:0] p);
    logic signed [63:0]      sh;
    logic signed [SUM_W-1:0] q;
    sh = p >>> Q_FRAC;
    q  = sh[SUM_W-1:0];
    if (p[63] && (p[Q_FRAC-1:0] != '0)) q = q + 50'sd1;
    return q;
  endfunction

  function automatic logic is_ovf(input logic signed [SUM_W-1:0] v);
    return (v[SUM_W-1:31] != '0) && (v[SUM_W-1:31] != '1);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (is_ovf(v)) r = v[SUM_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return r;
  endfunction

endpackage

// ----- sv/polynomial_horner_evaluator_unit.sv -----
// Polynomial store with Horner evaluation at a complex point, Q16.16.
// Commands enter on req when start is high and busy is low: write a
// coefficient, read one back, or evaluate at (point_re, point_im).
// Each command gives exactly one rsp word, shown for one cycle with done;
// the receiver cannot stall, so the word must be taken in that cycle.
// The user must write poly_degree through cfg_we/cfg_wdata while the unit
// is idle; the block does not enforce this. After accept a write or refused
// command takes decode, a read decode and read, an evaluate decode, load and
// a Horner step per degree (multiply, then scale/add/saturate) on one complex
// multiply-add unit, so the step loop sets the evaluate time; busy is high
// for the whole command. After reset the coefficient store is swept to zero,
// one entry a cycle, all MAX_DEGREE+1 entries with busy high; cfg writes are
// taken meanwhile. poly_degree resets to 0. Indexes above the degree return
// status 1; any saturation during evaluation returns status 2.
module polynomial_horner_evaluator_unit #(
  parameter int unsigned MAX_DEGREE = phe_pkg::MAX_DEGREE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  phe_pkg::phe_req_t             req,
  output logic                          done,
  output phe_pkg::phe_rsp_t             rsp,
  input  logic                          cfg_we,
  input  logic [phe_pkg::DEG_W-1:0]     cfg_wdata
);
  import phe_pkg::*;

  localparam int unsigned DEPTH = MAX_DEGREE + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DEGREE);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CLEAR  = 7'b0000010,
    S_DECODE = 7'b0000100,
    S_READ   = 7'b0001000,
    S_LOAD   = 7'b0010000,
    S_MUL    = 7'b0100000,
    S_ADD    = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [DEG_W-1:0] poly_degree;
  logic [DEG_W-1:0] deg_eff;
  logic [DEG_W-1:0] ptr;
  logic [AW-1:0]    clr_addr;
  phe_req_t         req_q;
  phe_rsp_t         rsp_q, rsp_next;
  logic             done_q, done_next;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  logic               mem_we, rd_en;
  logic [AW-1:0]      mem_waddr, rd_addr;
  logic signed [31:0] mem_wdata;

  logic signed [31:0] acc_re, acc_im;
  logic signed [63:0] prod_ac, prod_bd, prod_ad, prod_bc;
  logic               ovf;

  logic signed [SUM_W-1:0] sum_re, sum_im;
  logic signed [31:0]      sat_re, sat_im;
  logic                    step_ovf;
  logic                    in_range;

  assign deg_eff  = (poly_degree > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : poly_degree;
  assign in_range = (req_q.coeff_index <= deg_eff);

  // scale, accumulate and clip one Horner step
  assign sum_re = q_trunc(prod_ac) - q_trunc(prod_bd) + {{(SUM_W-32){rdata[31]}}, rdata};
  assign sum_im = q_trunc(prod_ad) + q_trunc(prod_bc);
  assign sat_re = sat32(sum_re);
  assign sat_im = sat32(sum_im);
  assign step_ovf = is_ovf(sum_re) | is_ovf(sum_im);

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = clr_addr;
    mem_wdata  = '0;
    rd_en      = 1'b0;
    rd_addr    = AW'(ptr - DEG_W'(1));
    rsp_next   = '{value_re: '0, value_im: '0, status: ST_OK};
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == LAST_ADDR) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (req_q.cmd)
          CMD_WRITE: begin
            if (in_range) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(req_q.coeff_index);
              mem_wdata = req_q.coeff_value;
            end else begin
              rsp_next.status = ST_RANGE;
            end
          end
          CMD_READ: begin
            if (in_range) begin
              rd_en      = 1'b1;
              rd_addr    = AW'(req_q.coeff_index);
              state_next = S_READ;
            end else begin
              rsp_next.status = ST_RANGE;
            end
          end
          CMD_EVAL: begin
            rd_en      = 1'b1;
            rd_addr    = AW'(deg_eff);
            state_next = S_LOAD;
          end
          default: ;
        endcase
      end
      S_READ: begin
        rsp_next.value_re = rdata;
        state_next        = S_IDLE;
      end
      S_LOAD: begin
        if (ptr == '0) begin
          rsp_next.value_re = rdata;
          state_next        = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_ADD;
      end
      S_ADD: begin
        if (ptr == '0) begin
          rsp_next.value_re = sat_re;
          rsp_next.value_im = (req_q.point_im == '0) ? '0 : sat_im;
          rsp_next.status   = (ovf || step_ovf) ? ST_OVF : ST_OK;
          state_next        = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          state_next = S_MUL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign done_next = (state != S_IDLE) && (state != S_CLEAR) && (state_next == S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en)  rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      poly_degree <= '0;
      done_q      <= 1'b0;
    end else begin
      state  <= state_next;
      done_q <= done_next;
      if (cfg_we) poly_degree <= cfg_wdata;
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) req_q <= req;
    if (done_next) rsp_q <= rsp_next;
    if (state == S_DECODE) ptr <= deg_eff;
    if (rd_en && (state == S_LOAD || state == S_ADD)) ptr <= ptr - DEG_W'(1);
    if (state == S_LOAD) begin
      acc_re <= rdata;
      acc_im <= '0;
      ovf    <= 1'b0;
    end
    if (state == S_MUL) begin
      prod_ac <= $signed(acc_re) * $signed(req_q.point_re);
      prod_bd <= $signed(acc_im) * $signed(req_q.point_im);
      prod_ad <= $signed(acc_re) * $signed(req_q.point_im);
      prod_bc <= $signed(acc_im) * $signed(req_q.point_re);
    end
    if (state == S_ADD) begin
      acc_re <= sat_re;
      acc_im <= sat_im;
      ovf    <= ovf | step_ovf;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = done_q;
  assign rsp  = rsp_q;

`include "assert_macros.svh"

  `CHECK_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `CHECK_NOW(a_done_after_work, done, $past(busy) && !$past(done), "done without prior work")
  `CHECK_NOW(a_ovf_only_eval, done && (rsp.status == ST_OVF), req_q.cmd == CMD_EVAL, "overflow on non-evaluate command")
  `CHECK_NOW(a_range_zero, done && (rsp.status == ST_RANGE), (rsp.value_re == '0) && (rsp.value_im == '0), "refused command returned data")

endmodule
